[rtl/sip_trt_pkg.sv]
// ----------------------------------------------------------------------------
// sip_trt_pkg
// Shared types and constants for the transaction retransmit timer block.
// ----------------------------------------------------------------------------
`default_nettype none

package sip_trt_pkg;

   // Table size and derived index width
   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Field widths fixed by the interface
   localparam int T1_W     = 16;
   localparam int T2_W     = 20;
   localparam int RING_W   = 24;
   localparam int CSR_W    = 24;
   localparam int CSR_AW   = 2;
   localparam int TIME_W   = 32;
   localparam int SLOTID_W = 4;
   localparam int TIMEOUT_SHIFT = 6;  // timeout is 64 times t1

   // Reset values of the timer registers
   localparam logic [T1_W-1:0]   T1_RESET   = 16'd500;
   localparam logic [T2_W-1:0]   T2_RESET   = 20'd4000;
   localparam logic [RING_W-1:0] RING_RESET = 24'd180000;

   // Register indexes on the csr port
   localparam logic [CSR_AW-1:0] CSR_T1   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_T2   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_RING = 2'd2;

   typedef enum logic [1:0] {
      OP_OPEN  = 2'd0,
      OP_PROV  = 2'd1,
      OP_FINAL = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_DONE    = 2'd0,
      KIND_BUSY    = 2'd1,
      KIND_RESEND  = 2'd2,
      KIND_TIMEOUT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OP,
      ST_WALK,
      ST_WRITE,
      ST_FLUSH
   } state_type;

   // One row of the slot table memory
   typedef struct packed {
      logic              invite;
      logic              resending;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] retry_at;
      logic [TIME_W-1:0] deadline;
   } entry_type;

endpackage

`default_nettype wire

[rtl/sip_transaction_retransmit_timers.sv]
// ----------------------------------------------------------------------------
// sip_transaction_retransmit_timers
// Slot table of transaction timers: open, provisional, final and tick beats,
// with retransmit and timeout reports on the response stream.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Beat contents
//  --------+-----------+-----------------------------------------------------
//  req_*   | in        | tuser: op, is_invite   tdata: slot, now_ms
//  rsp_*   | out       | tuser: kind            tdata: slot_out  tlast: last
//  csr_*   | in        | write enable, register index, write data
//
//  Open, provisional and final pass through ST_OP, which waits for the output
//  register. A tick runs ST_WALK, a ST_WRITE per retransmitted slot, then
//  ST_FLUSH; the walk reads one table row per cycle through the single read port
//  unless a rsp stall holds it. One beat is worked on at a time; the output
//  register lets the next req beat be taken while a response still waits.
//  Reset clears all valid bits at once; table rows need no clearing pass.
//
`default_nettype none

module sip_transaction_retransmit_timers (
   input  wire logic        clock,
   input  wire logic        reset,
   // req: tdata = slot[3:0], now_ms[35:4], zero [39:36]
   //      tuser = op[1:0], is_invite[2]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic [2:0]  req_tuser,
   // rsp: tdata = slot_out[3:0], zero [7:4]; tuser = kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   // csr
   input  wire logic        csr_we,
   input  wire logic [sip_trt_pkg::CSR_AW-1:0] csr_addr,
   input  wire logic [sip_trt_pkg::CSR_W-1:0]  csr_wdata
);

   localparam int SLOTS  = sip_trt_pkg::SLOTS;
   localparam int SLOT_W = sip_trt_pkg::SLOT_W;
   localparam int TIME_W = sip_trt_pkg::TIME_W;
   localparam int SID_W  = sip_trt_pkg::SLOTID_W;
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

   // Wrap-safe "now has reached at"
   function automatic logic reached(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] at);
      logic [TIME_W-1:0] diff;
      diff = now - at;
      return !diff[TIME_W-1];
   endfunction

   // Timer registers
   logic [sip_trt_pkg::T1_W-1:0]   t1_ff;
   logic [sip_trt_pkg::T2_W-1:0]   t2_ff;
   logic [sip_trt_pkg::RING_W-1:0] ring_ff;

   // Control state
   sip_trt_pkg::state_type state_ff, state_in;
   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers
   sip_trt_pkg::op_type    op_ff, op_in;
   logic [SID_W-1:0]       slot_ff, slot_in;
   logic                   inside_ff, inside_in;
   logic                   invite_ff, invite_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [TIME_W-1:0]      nv_ff, nv_in;
   sip_trt_pkg::kind_type  pend_kind_ff, pend_kind_in;
   logic [SID_W-1:0]       pend_slot_ff, pend_slot_in;
   sip_trt_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [SID_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Slot table memory, one write and one read port
   sip_trt_pkg::entry_type entry_ram_ff [SLOTS];
   sip_trt_pkg::entry_type rd_data_ff;
   logic                   rd_en;
   logic [SLOT_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [SLOT_W-1:0]      wr_addr;
   sip_trt_pkg::entry_type wr_data;

   // Walk and op helpers
   logic                   req_fire;
   logic                   out_free;
   logic                   emit_ok;
   logic                   cur_valid;
   logic                   dl_hit;
   logic                   rs_hit;
   logic [TIME_W-1:0]      dbl;
   logic [TIME_W-1:0]      capped;
   logic [TIME_W-1:0]      t1_ext;
   logic [TIME_W-1:0]      t2_ext;
   logic [TIME_W-1:0]      ring_ext;
   sip_trt_pkg::op_type    req_op;
   logic [SID_W-1:0]       req_slot;

   assign req_tready = (state_ff == sip_trt_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = sip_trt_pkg::op_type'(req_tuser[1:0]);
   assign req_slot   = req_tdata[SID_W-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_ok   = !pend_valid_ff || out_free;
   assign cur_valid = valid_ff[idx_ff];

   assign t1_ext   = TIME_W'(t1_ff);
   assign t2_ext   = TIME_W'(t2_ff);
   assign ring_ext = TIME_W'(ring_ff);

   // Evaluate the row that the walk has just read
   assign dl_hit = reached(now_ff, rd_data_ff.deadline);
   assign rs_hit = rd_data_ff.resending && reached(now_ff, rd_data_ff.retry_at);
   assign dbl    = rd_data_ff.interval[TIME_W-1] ? '1 : {rd_data_ff.interval[TIME_W-2:0], 1'b0};
   assign capped = (!rd_data_ff.invite && (dbl > t2_ext)) ? t2_ext : dbl;

   // Timer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff   <= sip_trt_pkg::T1_RESET;
         t2_ff   <= sip_trt_pkg::T2_RESET;
         ring_ff <= sip_trt_pkg::RING_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            sip_trt_pkg::CSR_T1:   t1_ff   <= csr_wdata[sip_trt_pkg::T1_W-1:0];
            sip_trt_pkg::CSR_T2:   t2_ff   <= csr_wdata[sip_trt_pkg::T2_W-1:0];
            sip_trt_pkg::CSR_RING: ring_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state, table access and response loading
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      inside_in     = inside_ff;
      invite_in     = invite_ff;
      now_in        = now_ff;
      nv_in         = nv_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data_ff;

      case (state_ff)
         sip_trt_pkg::ST_IDLE: begin
            // Take a beat and start the table read it needs
            if (req_fire) begin
               op_in     = req_op;
               slot_in   = req_slot;
               inside_in = (32'(req_slot) < SLOTS);
               invite_in = req_tuser[2];
               now_in    = req_tdata[SID_W +: TIME_W];
               rd_en     = 1'b1;
               if (req_op == sip_trt_pkg::OP_TICK) begin
                  idx_in   = '0;
                  rd_addr  = '0;
                  state_in = sip_trt_pkg::ST_WALK;
               end else begin
                  idx_in   = SLOT_W'(req_slot);
                  rd_addr  = SLOT_W'(req_slot);
                  state_in = sip_trt_pkg::ST_OP;
               end
            end
         end

         sip_trt_pkg::ST_OP: begin
            // Apply a slot operation and answer with one beat
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = slot_ff;
               rsp_last_in  = 1'b1;
               rsp_kind_in  = sip_trt_pkg::KIND_DONE;
               state_in     = sip_trt_pkg::ST_IDLE;
               case (op_ff)
                  sip_trt_pkg::OP_OPEN: begin
                     if (!inside_ff || cur_valid) begin
                        rsp_kind_in = sip_trt_pkg::KIND_BUSY;
                     end else begin
                        valid_in[idx_ff]  = 1'b1;
                        wr_en             = 1'b1;
                        wr_data.invite    = invite_ff;
                        wr_data.resending = 1'b1;
                        wr_data.interval  = t1_ext;
                        wr_data.retry_at  = now_ff + t1_ext;
                        wr_data.deadline  = now_ff + (t1_ext << sip_trt_pkg::TIMEOUT_SHIFT);
                     end
                  end
                  sip_trt_pkg::OP_PROV: begin
                     if (!inside_ff || !cur_valid) begin
                        rsp_kind_in = sip_trt_pkg::KIND_BUSY;
                     end else begin
                        wr_en = 1'b1;
                        if (rd_data_ff.invite) begin
                           wr_data.resending = 1'b0;
                           wr_data.deadline  = now_ff + ring_ext;
                        end else begin
                           wr_data.interval = t2_ext;
                        end
                     end
                  end
                  sip_trt_pkg::OP_FINAL: begin
                     if (!inside_ff || !cur_valid) begin
                        rsp_kind_in = sip_trt_pkg::KIND_BUSY;
                     end else begin
                        valid_in[idx_ff] = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         sip_trt_pkg::ST_WALK: begin
            if (!cur_valid || (!dl_hit && !rs_hit)) begin
               // Nothing due: advance
               if (idx_ff == LAST_IDX) begin
                  state_in = sip_trt_pkg::ST_FLUSH;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + 1'b1;
                  idx_in  = idx_ff + 1'b1;
               end
            end else if (emit_ok) begin
               // Push the held report out, hold this one
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pend_kind_ff;
                  rsp_slot_in  = pend_slot_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = SID_W'(idx_ff);
               if (dl_hit) begin
                  pend_kind_in     = sip_trt_pkg::KIND_TIMEOUT;
                  valid_in[idx_ff] = 1'b0;
                  if (idx_ff == LAST_IDX) begin
                     state_in = sip_trt_pkg::ST_FLUSH;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = idx_ff + 1'b1;
                     idx_in  = idx_ff + 1'b1;
                  end
               end else begin
                  pend_kind_in = sip_trt_pkg::KIND_RESEND;
                  nv_in        = capped;
                  state_in     = sip_trt_pkg::ST_WRITE;
               end
            end
         end

         sip_trt_pkg::ST_WRITE: begin
            // Reschedule the slot and read the next row
            wr_en             = 1'b1;
            wr_data.interval  = nv_ff;
            wr_data.retry_at  = now_ff + nv_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = sip_trt_pkg::ST_FLUSH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
               state_in = sip_trt_pkg::ST_WALK;
            end
         end

         sip_trt_pkg::ST_FLUSH: begin
            // Close the tick: last report, or a single done beat
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = sip_trt_pkg::ST_IDLE;
               if (pend_valid_ff) begin
                  rsp_kind_in = pend_kind_ff;
                  rsp_slot_in = pend_slot_ff;
               end else begin
                  rsp_kind_in = sip_trt_pkg::KIND_DONE;
                  rsp_slot_in = '0;
               end
            end
         end

         default: state_in = sip_trt_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sip_trt_pkg::ST_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      inside_ff    <= inside_in;
      invite_ff    <= invite_in;
      now_ff       <= now_in;
      nv_ff        <= nv_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Slot table memory; a row is never written and read in the same cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_ram_ff[rd_addr];
      end
   end

   // Read and write never hit the same row at once
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("table read and write collide on one row");

   // A rescheduled slot is still open
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sip_trt_pkg::ST_WRITE) |-> valid_ff[idx_ff])
      else $error("reschedule of a freed slot");

   // Held reports exist only during a tick
   a_pend_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == sip_trt_pkg::ST_WALK ||
                         state_ff == sip_trt_pkg::ST_WRITE ||
                         state_ff == sip_trt_pkg::ST_FLUSH))
      else $error("held report outside a tick");

   // A slot operation goes straight to its single answer step
   a_op_path: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op != sip_trt_pkg::OP_TICK) |=> (state_ff == sip_trt_pkg::ST_OP))
      else $error("slot operation did not enter its answer step");

endmodule

`default_nettype wire

[dv/sip_trt_report_checker.sv]
// ----------------------------------------------------------------------------
// sip_trt_report_checker
// Watches the req, rsp and csr ports of the transaction timer block. It keeps
// its own copy of the slot table and timer registers, works out the reports
// owed for every accepted req beat, and compares each rsp beat against the
// oldest owed report.
// ----------------------------------------------------------------------------

module sip_trt_report_checker
   import sip_trt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic [39:0]       req_tdata,   // slot[3:0], now_ms[35:4], zero
   input  wire logic [2:0]        req_tuser,   // op[1:0], is_invite[2]
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [7:0]        rsp_tdata,   // slot_out[3:0], zero
   input  wire logic [1:0]        rsp_tuser,   // kind[1:0]
   input  wire logic              rsp_tlast,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     reports_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      kind_type              kind;
      logic [SLOTID_W-1:0]   slot;
      logic                  last;
   } report_type;

   report_type owed_reports[$];

   // Timer registers as the block should hold them
   logic [T1_W-1:0]   t1_ms;
   logic [T2_W-1:0]   t2_ms;
   logic [RING_W-1:0] ringing_ms;

   // Slot table copy
   logic              slot_open[SLOTS];
   logic              slot_invite[SLOTS];
   logic              slot_resending[SLOTS];
   logic [TIME_W-1:0] slot_interval[SLOTS];
   logic [TIME_W-1:0] slot_retry_at[SLOTS];
   logic [TIME_W-1:0] slot_deadline[SLOTS];

   initial begin
      mismatch_count = 0;
      reports_owed   = 0;
   end

   // Wrap-safe compare: now has reached at when the 32-bit difference is
   // in the lower half of the circle
   function automatic logic time_reached(logic [TIME_W-1:0] now,
                                         logic [TIME_W-1:0] at);
      logic [TIME_W-1:0] diff;
      diff = now - at;
      return !diff[TIME_W-1];
   endfunction

   task automatic owe(kind_type kind, logic [SLOTID_W-1:0] slot, logic last);
      report_type r;
      r.kind = kind;
      r.slot = slot;
      r.last = last;
      owed_reports.insert(owed_reports.size(), r);
   endtask

   // Apply one req beat to the table copy and queue the reports it causes
   task automatic apply_request(op_type op, logic [SLOTID_W-1:0] s, logic inv,
                                logic [TIME_W-1:0] now);
      kind_type            walk_kind[SLOTS];
      logic [SLOTID_W-1:0] walk_slot[SLOTS];
      int                  n_due;
      logic [TIME_W-1:0]   nv;
      n_due = 0;
      case (op)
         OP_TICK: begin
            // walk every open slot in index order
            for (int i = 0; i < SLOTS; i++) begin
               if (!slot_open[i])
                  continue;
               if (time_reached(now, slot_deadline[i])) begin
                  slot_open[i]     = 1'b0;
                  walk_kind[n_due] = KIND_TIMEOUT;
                  walk_slot[n_due] = SLOTID_W'(i);
                  n_due++;
               end else if (slot_resending[i] && time_reached(now, slot_retry_at[i])) begin
                  // double the interval, saturate, cap non-INVITE at t2
                  nv = slot_interval[i][TIME_W-1] ? '1 : (slot_interval[i] << 1);
                  if (!slot_invite[i] && nv > TIME_W'(t2_ms))
                     nv = TIME_W'(t2_ms);
                  slot_interval[i] = nv;
                  slot_retry_at[i] = now + nv;
                  walk_kind[n_due] = KIND_RESEND;
                  walk_slot[n_due] = SLOTID_W'(i);
                  n_due++;
               end
            end
            if (n_due == 0)
               owe(KIND_DONE, '0, 1'b1);
            for (int j = 0; j < n_due; j++)
               owe(walk_kind[j], walk_slot[j], j == n_due - 1);
         end
         OP_OPEN: begin
            if (int'(s) >= SLOTS || slot_open[s]) begin
               owe(KIND_BUSY, s, 1'b1);
            end else begin
               slot_open[s]      = 1'b1;
               slot_invite[s]    = inv;
               slot_resending[s] = 1'b1;
               slot_interval[s]  = TIME_W'(t1_ms);
               slot_retry_at[s]  = now + TIME_W'(t1_ms);
               slot_deadline[s]  = now + (TIME_W'(t1_ms) << TIMEOUT_SHIFT);
               owe(KIND_DONE, s, 1'b1);
            end
         end
         default: begin
            if (int'(s) >= SLOTS || !slot_open[s]) begin
               owe(KIND_BUSY, s, 1'b1);
            end else begin
               if (op == OP_PROV) begin
                  // INVITE stops resending and waits for the callee
                  if (slot_invite[s]) begin
                     slot_resending[s] = 1'b0;
                     slot_deadline[s]  = now + TIME_W'(ringing_ms);
                  end else begin
                     slot_interval[s] = TIME_W'(t2_ms);
                  end
               end else begin
                  slot_open[s] = 1'b0;
               end
               owe(KIND_DONE, s, 1'b1);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         t1_ms      = T1_RESET;
         t2_ms      = T2_RESET;
         ringing_ms = RING_RESET;
         for (int i = 0; i < SLOTS; i++)
            slot_open[i] = 1'b0;
         owed_reports.delete();
      end else begin
         // check the rsp beat first: it always belongs to an earlier req beat
         if (rsp_tvalid && rsp_tready) begin
            if (owed_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no beat, got kind %0d tdata %h last %0d",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
            end else begin
               want = owed_reports.pop_front();
               if (rsp_tuser != want.kind || rsp_tdata != {4'b0, want.slot}
                   || rsp_tlast != want.last) begin
                  mismatch_count++;
                  $display(
                     "%0t: expected kind %0d tdata %h last %0d, got kind %0d tdata %h last %0d",
                     $time, want.kind, {4'b0, want.slot}, want.last,
                     rsp_tuser, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_request(op_type'(req_tuser[1:0]), req_tdata[3:0], req_tuser[2],
                          req_tdata[35:4]);
         if (csr_we) begin
            case (csr_addr)
               CSR_T1:   t1_ms      = csr_wdata[T1_W-1:0];
               CSR_T2:   t2_ms      = csr_wdata[T2_W-1:0];
               CSR_RING: ringing_ms = csr_wdata[RING_W-1:0];
               default: ;
            endcase
         end
      end
      reports_owed = owed_reports.size();
   end

endmodule

[dv/sip_transaction_retransmit_timers_tb.sv]
// ----------------------------------------------------------------------------
// sip_transaction_retransmit_timers_tb
// Drives open, provisional, final and tick beats into the transaction timer
// block: a directed pass over the corner cases, then phases of random traffic
// under several timer settings and handshake idling patterns. The report
// checker beside the block predicts and compares every rsp beat.
// ----------------------------------------------------------------------------

module sip_transaction_retransmit_timers_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sip_trt_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 40;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [39:0]       req_tdata;   // slot[3:0], now_ms[35:4], zero [39:36]
   logic [2:0]        req_tuser;   // op[1:0], is_invite[2]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [7:0]        rsp_tdata;   // slot_out[3:0], zero [7:4]
   logic [1:0]        rsp_tuser;   // kind[1:0]
   logic              rsp_tlast;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_addr;
   logic [CSR_W-1:0]  csr_wdata;

   int mismatch_count;
   int reports_owed;
   int cycle_count = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int cur_t1      = 500;
   int cur_ring    = 180000;
   logic [TIME_W-1:0] clock_ms;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   sip_transaction_retransmit_timers uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   sip_trt_report_checker report_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .reports_owed   (reports_owed)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sip_transaction_retransmit_timers_tb failed");
         $finish;
      end
   end

   // Stall the rsp side at random
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // Present one req beat, idling first at random, and hold it until taken
   task automatic send_beat(op_type op, logic [SLOTID_W-1:0] s, logic inv,
                            logic [TIME_W-1:0] now);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, now, s};
      req_tuser  <= {inv, op};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Go quiet until every owed report has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (reports_owed != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly well-formed traffic on a moving clock, with some noise beats
   task automatic random_beat();
      int pick;
      int step;
      if ($urandom_range(19) == 0)
         drain();
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_beat(OP_OPEN, SLOTID_W'($urandom_range(SLOTS - 1)),
                   1'($urandom_range(1)), clock_ms);
      end else if (pick < 60) begin
         // advance time: mostly near the retransmit interval, sometimes far
         step = $urandom_range(99);
         if (step < 70)
            step = $urandom_range(2 * cur_t1 + 1);
         else if (step < 90)
            step = $urandom_range(64 * cur_t1 + 1);
         else
            step = $urandom_range(64 * cur_t1 + cur_ring);
         clock_ms += TIME_W'(step);
         send_beat(OP_TICK, '0, 1'($urandom_range(1)), clock_ms);
      end else if (pick < 75) begin
         send_beat(OP_PROV, SLOTID_W'($urandom_range(SLOTS - 1)),
                   1'($urandom_range(1)), clock_ms);
      end else if (pick < 88) begin
         send_beat(OP_FINAL, SLOTID_W'($urandom_range(SLOTS - 1)),
                   1'($urandom_range(1)), clock_ms);
      end else begin
         send_beat(op_type'($urandom_range(3)), SLOTID_W'($urandom_range(SLOTS - 1)),
                   1'($urandom_range(1)), $urandom());
      end
   endtask

   // One traffic phase under one timer setting and idling pattern
   task automatic run_phase(logic [CSR_W-1:0] t1_word, logic [CSR_W-1:0] t2_word,
                            logic [CSR_W-1:0] ring_word, int idle, int stall,
                            int n_random);
      drain();
      write_reg(CSR_T1, t1_word);
      write_reg(CSR_T2, t2_word);
      write_reg(CSR_RING, ring_word);
      cur_t1    = int'(t1_word[T1_W-1:0]);
      cur_ring  = int'(ring_word[RING_W-1:0]);
      idle_pct  = idle;
      stall_pct = stall;
      // time out whatever the last phase left open
      clock_ms += 32'h0200_0000;
      send_beat(OP_TICK, '0, 1'b0, clock_ms);
      // fill the table at one instant, then make every slot due at once
      for (int s = 0; s < SLOTS; s++)
         send_beat(OP_OPEN, SLOTID_W'(s), 1'($urandom_range(1)), clock_ms);
      clock_ms += TIME_W'(cur_t1);
      send_beat(OP_TICK, '0, 1'b0, clock_ms);
      repeat (n_random)
         random_beat();
   endtask

   initial begin
      logic [TIME_W-1:0] t0;
      t0         = 32'hFFFF_FF00;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      clock_ms   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, slots that are not open
      send_beat(OP_TICK, '0, 1'b1, 32'd0);
      send_beat(OP_PROV, 4'd3, 1'b0, 32'd0);
      send_beat(OP_FINAL, 4'd3, 1'b0, 32'd0);
      // opens just before the time counter wraps, one on a busy slot
      send_beat(OP_OPEN, 4'd0, 1'b1, t0);
      send_beat(OP_OPEN, 4'd0, 1'b0, t0);
      send_beat(OP_OPEN, 4'd15, 1'b0, t0);
      send_beat(OP_OPEN, 4'd7, 1'b0, t0);
      // one short of the retransmit time, then exactly on it
      send_beat(OP_TICK, '0, 1'b0, t0 + 499);
      send_beat(OP_TICK, '0, 1'b0, t0 + 500);
      // provisional on INVITE and non-INVITE
      send_beat(OP_PROV, 4'd0, 1'b0, t0 + 600);
      send_beat(OP_PROV, 4'd7, 1'b0, t0 + 600);
      // non-INVITE doubling capped at t2
      send_beat(OP_TICK, '0, 1'b0, t0 + 1500);
      send_beat(OP_FINAL, 4'd15, 1'b1, t0 + 1600);
      send_beat(OP_FINAL, 4'd15, 1'b0, t0 + 1600);
      // transaction timeout, then the ringing deadline
      send_beat(OP_TICK, '0, 1'b0, t0 + 32000);
      send_beat(OP_TICK, '0, 1'b0, t0 + 180600);
      // signed compare at half the circle away, then just inside
      send_beat(OP_OPEN, 4'd9, 1'b1, 32'hFFFF_FFFF);
      send_beat(OP_TICK, '0, 1'b0, 32'h8000_7CFF);
      send_beat(OP_TICK, '0, 1'b0, 32'd31998);
      send_beat(OP_TICK, '0, 1'b0, 32'd31999);
      send_beat(OP_OPEN, 4'd5, 1'b0, 32'd40000);
      send_beat(OP_PROV, 4'd5, 1'b1, 32'd40001);
      send_beat(OP_FINAL, 4'd5, 1'b0, 32'd40002);

      clock_ms = $urandom();
      run_phase(24'd500, 24'd4000, 24'd180000, 0, 0, 9);
      run_phase(24'd1, 24'd1, 24'd1, 57, 0, 9);
      run_phase(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 0, 57, 9);
      // t1 of zero after masking: slots are due on every tick
      run_phase(24'h01_0000, 24'($urandom_range(8000, 1)),
                24'($urandom_range(500000, 1)), 33, 33, 9);

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && reports_owed == 0)
         $display("sip_transaction_retransmit_timers_tb passed");
      else
         $display("sip_transaction_retransmit_timers_tb failed");
      $finish;
   end

endmodule
